/* src/hqvs_pkg.sv */
`timescale 1ns / 1ps

package hqvs_pkg;

  // block sizes
  localparam int ANGLE_BITS     = 16;
  localparam int ACC_BITS       = 32;
  localparam int TYPE_COUNT     = 8;
  localparam int SUBEVENT_COUNT = 8;

  // fixed field widths
  localparam int IO_W       = 32;
  localparam int WEIGHT_W   = 16;
  localparam int MASK_W     = 8;
  localparam int COUNT_W    = 8;
  localparam int HARM_W     = 4;
  localparam int PTYPE_W    = 3;
  localparam int SUBSEL_W   = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  // rotator datapath
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int PHASE_W      = 32;
  localparam int XY_W         = 32;
  localparam int Z_W          = PHASE_W + 1;
  localparam int TRIG_W       = XY_W;

  // weight product, trig product and rounding
  localparam int PROD_P_W    = 2 * WEIGHT_W + 1;
  localparam int PROD_W      = PROD_P_W + TRIG_W;
  localparam int ROUND_SHIFT = 40;
  localparam int TERM_W      = PROD_W - ROUND_SHIFT;

  // accumulator arithmetic width, with headroom over both load and accumulator
  localparam int WIDE_W = ((ACC_BITS > IO_W) ? ACC_BITS : IO_W) + 2;

  // register reset values
  localparam logic [HARM_W-1:0]          HARMONIC_RST = HARM_W'(2);
  localparam logic [PTYPE_W-1:0]         PTYPE_RST    = '0;
  localparam logic signed [SUBSEL_W-1:0] SUBSEL_RST   = '1;

  // start vector, prescaled by the inverse rotator gain, Q2.30
  localparam logic signed [XY_W-1:0] CORDIC_X0 = XY_W'(32'h26DD3B6A);

  // arctangent of 2^-i in 32-bit turn units
  localparam logic [PHASE_W-1:0] ATAN_TURN [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HARMONIC        = 2'd0,
    REG_PARTICLE_TYPE   = 2'd1,
    REG_SUBEVENT_SELECT = 2'd2
  } cfg_reg_t;

  // one rotator stage
  typedef struct packed {
    logic                   valid;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } rot_t;

  // per-item control handed to the update stage
  typedef struct packed {
    logic load;
    logic sel;
    logic daughter;
    logic neg;
  } item_ctrl_t;

  // clamp a wide signed value to the accumulator range
  function automatic logic signed [ACC_BITS-1:0] sat_acc(input logic signed [WIDE_W-1:0] v);
    logic fits;
    fits = (v[WIDE_W-1:ACC_BITS-1] == {(WIDE_W-ACC_BITS+1){v[WIDE_W-1]}});
    if (fits) begin
      return v[ACC_BITS-1:0];
    end
    return {v[WIDE_W-1], {(ACC_BITS-1){~v[WIDE_W-1]}}};
  endfunction

endpackage

/* src/hqvs_cell.sv */
`timescale 1ns / 1ps

module hqvs_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [hqvs_pkg::STEP_W-1:0]  step,
  input  hqvs_pkg::rot_t               din,
  output hqvs_pkg::rot_t               dout
);

  logic signed [hqvs_pkg::XY_W-1:0] x_sh;
  logic signed [hqvs_pkg::XY_W-1:0] y_sh;
  logic signed [hqvs_pkg::XY_W-1:0] x_next;
  logic signed [hqvs_pkg::XY_W-1:0] y_next;
  logic signed [hqvs_pkg::Z_W-1:0]  ang;
  logic signed [hqvs_pkg::Z_W-1:0]  z_next;

  logic                             valid;
  logic signed [hqvs_pkg::XY_W-1:0] x;
  logic signed [hqvs_pkg::XY_W-1:0] y;
  logic signed [hqvs_pkg::Z_W-1:0]  z;

  // one micro-rotation, direction from the sign of the residual angle
  always_comb begin
    x_sh = $signed(din.x) >>> step;
    y_sh = $signed(din.y) >>> step;
    ang  = $signed({1'b0, hqvs_pkg::ATAN_TURN[step]});
    if (!din.z[hqvs_pkg::Z_W-1]) begin
      x_next = din.x - y_sh;
      y_next = din.y + x_sh;
      z_next = din.z - ang;
    end else begin
      x_next = din.x + y_sh;
      y_next = din.y - x_sh;
      z_next = din.z + ang;
    end
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= din.valid;
    end
  end

  // stage data
  always_ff @(posedge clk) begin
    x <= x_next;
    y <= y_next;
    z <= z_next;
  end

  always_comb begin
    dout.valid = valid;
    dout.x     = x;
    dout.y     = y;
    dout.z     = z;
  end

endmodule

/* src/hqvs_update.sv */
`timescale 1ns / 1ps

module hqvs_update (
  input  logic                                 clk,
  input  logic                                 rst,
  input  hqvs_pkg::rot_t                       fin,
  input  hqvs_pkg::item_ctrl_t                 ctrl,
  input  logic signed [hqvs_pkg::PROD_P_W-1:0] weight,
  input  logic signed [hqvs_pkg::IO_W-1:0]     load_x,
  input  logic signed [hqvs_pkg::IO_W-1:0]     load_y,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic signed [hqvs_pkg::IO_W-1:0]     vector_x,
  output logic signed [hqvs_pkg::IO_W-1:0]     vector_y,
  output logic [hqvs_pkg::COUNT_W-1:0]         daughters_subtracted,
  output logic                                 was_selected,
  output logic                                 done
);

  logic signed [hqvs_pkg::TRIG_W-1:0]   cos_v;
  logic signed [hqvs_pkg::TRIG_W-1:0]   sin_v;
  logic                                 prod_valid;
  logic signed [hqvs_pkg::PROD_W-1:0]   prod_x;
  logic signed [hqvs_pkg::PROD_W-1:0]   prod_y;
  logic signed [hqvs_pkg::PROD_W-1:0]   rnd_x;
  logic signed [hqvs_pkg::PROD_W-1:0]   rnd_y;
  logic                                 term_valid;
  logic signed [hqvs_pkg::TERM_W-1:0]   term_x;
  logic signed [hqvs_pkg::TERM_W-1:0]   term_y;
  logic                                 fire;
  logic signed [hqvs_pkg::ACC_BITS-1:0] acc_x;
  logic signed [hqvs_pkg::ACC_BITS-1:0] acc_y;
  logic signed [hqvs_pkg::ACC_BITS-1:0] acc_x_next;
  logic signed [hqvs_pkg::ACC_BITS-1:0] acc_y_next;
  logic signed [hqvs_pkg::WIDE_W-1:0]   acc_x_w;
  logic signed [hqvs_pkg::WIDE_W-1:0]   acc_y_w;
  logic [hqvs_pkg::COUNT_W-1:0]         count;
  logic [hqvs_pkg::COUNT_W-1:0]         count_next;
  logic                                 sel_next;

  // undo the half-turn fold
  assign cos_v = ctrl.neg ? -fin.x : fin.x;
  assign sin_v = ctrl.neg ? -fin.y : fin.y;

  // weight times trig
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= fin.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fin.valid) begin
      prod_x <= hqvs_pkg::PROD_W'(weight) * hqvs_pkg::PROD_W'(cos_v);
      prod_y <= hqvs_pkg::PROD_W'(weight) * hqvs_pkg::PROD_W'(sin_v);
    end
  end

  // round to Q25.0, nearest with ties upward
  assign rnd_x = prod_x + (hqvs_pkg::PROD_W'(1) <<< (hqvs_pkg::ROUND_SHIFT - 1));
  assign rnd_y = prod_y + (hqvs_pkg::PROD_W'(1) <<< (hqvs_pkg::ROUND_SHIFT - 1));

  // term register holds until the result register is free
  assign fire = term_valid && (!out_valid || out_ready);
  assign done = fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      term_valid <= 1'b0;
    end else if (prod_valid) begin
      term_valid <= 1'b1;
    end else if (fire) begin
      term_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_valid) begin
      term_x <= rnd_x[hqvs_pkg::PROD_W-1:hqvs_pkg::ROUND_SHIFT];
      term_y <= rnd_y[hqvs_pkg::PROD_W-1:hqvs_pkg::ROUND_SHIFT];
    end
  end

  assign acc_x_w = hqvs_pkg::WIDE_W'(acc_x);
  assign acc_y_w = hqvs_pkg::WIDE_W'(acc_y);

  // accumulator and daughter counter update
  always_comb begin
    acc_x_next = acc_x;
    acc_y_next = acc_y;
    count_next = count;
    sel_next   = 1'b0;
    if (ctrl.load) begin
      acc_x_next = hqvs_pkg::sat_acc(hqvs_pkg::WIDE_W'(load_x));
      acc_y_next = hqvs_pkg::sat_acc(hqvs_pkg::WIDE_W'(load_y));
    end else begin
      if (!ctrl.daughter) begin
        count_next = '0;
      end else if (ctrl.sel && (count != '1)) begin
        count_next = count + hqvs_pkg::COUNT_W'(1);
      end
      if (ctrl.sel) begin
        acc_x_next = hqvs_pkg::sat_acc(acc_x_w - hqvs_pkg::WIDE_W'(term_x));
        acc_y_next = hqvs_pkg::sat_acc(acc_y_w - hqvs_pkg::WIDE_W'(term_y));
        sel_next   = 1'b1;
      end
    end
  end

  // state doubles as the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_x        <= '0;
      acc_y        <= '0;
      count        <= '0;
      was_selected <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (fire) begin
        acc_x        <= acc_x_next;
        acc_y        <= acc_y_next;
        count        <= count_next;
        was_selected <= sel_next;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign vector_x             = acc_x_w[hqvs_pkg::IO_W-1:0];
  assign vector_y             = acc_y_w[hqvs_pkg::IO_W-1:0];
  assign daughters_subtracted = count;

endmodule

/* src/harmonic_q_vector_subtract.sv */
// channel   direction  handshake                  payload
// in        input      in_valid / in_ready        operation .. is_daughter
// out       output     out_valid / out_ready      vector_x, vector_y, daughters_subtracted,
//                                                 was_selected
// cfg       input      cfg_valid / cfg_ready      cfg_index, cfg_data
//
// one item is in flight at a time; after the input transfer a result passes the phase
// setup register, 16 rotator cells, trig multiply, rounding and result registers, and the
// next item can be taken in the cycle the result appears
// the 16-cell rotator row sets the latency; a stalled output holds only the rounding stage
// synchronous reset clears accumulators, daughter count and registers to their defaults
// cfg_ready is always high; the input waits while an item is in flight
`timescale 1ns / 1ps

module harmonic_q_vector_subtract (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   operation,
  input  logic signed [hqvs_pkg::IO_W-1:0]       load_x,
  input  logic signed [hqvs_pkg::IO_W-1:0]       load_y,
  input  logic [hqvs_pkg::ANGLE_BITS-1:0]        phi_angle,
  input  logic [hqvs_pkg::WEIGHT_W-1:0]          particle_weight,
  input  logic signed [hqvs_pkg::WEIGHT_W-1:0]   extra_weight,
  input  logic [hqvs_pkg::MASK_W-1:0]            type_bits,
  input  logic [hqvs_pkg::MASK_W-1:0]            subevent_bits,
  input  logic                                   is_daughter,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [hqvs_pkg::IO_W-1:0]       vector_x,
  output logic signed [hqvs_pkg::IO_W-1:0]       vector_y,
  output logic [hqvs_pkg::COUNT_W-1:0]           daughters_subtracted,
  output logic                                   was_selected,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [hqvs_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [hqvs_pkg::CFG_DATA_W-1:0]        cfg_data
);

  logic [hqvs_pkg::HARM_W-1:0]                 harmonic;
  logic [hqvs_pkg::PTYPE_W-1:0]                particle_type;
  logic signed [hqvs_pkg::SUBSEL_W-1:0]        subevent_select;

  logic                                        in_xfer;
  logic                                        busy;
  logic                                        start;
  logic                                        done;
  logic [hqvs_pkg::HARM_W+hqvs_pkg::ANGLE_BITS-1:0] harm_prod;
  logic [hqvs_pkg::PHASE_W-1:0]                phase;
  logic [hqvs_pkg::PHASE_W-1:0]                z_fold;
  logic                                        neg;
  logic                                        type_ok;
  logic                                        sub_ok;
  logic signed [hqvs_pkg::PROD_P_W-1:0]        weight_prod;
  hqvs_pkg::item_ctrl_t                        ctrl_in;

  hqvs_pkg::item_ctrl_t                        item_ctrl;
  logic signed [hqvs_pkg::PROD_P_W-1:0]        item_weight;
  logic signed [hqvs_pkg::Z_W-1:0]             item_z;
  logic signed [hqvs_pkg::IO_W-1:0]            item_lx;
  logic signed [hqvs_pkg::IO_W-1:0]            item_ly;

  hqvs_pkg::rot_t                              chain [hqvs_pkg::CORDIC_STEPS+1];

  assign cfg_ready = 1'b1;
  assign in_ready  = !busy;
  assign in_xfer   = in_valid && in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      harmonic        <= hqvs_pkg::HARMONIC_RST;
      particle_type   <= hqvs_pkg::PTYPE_RST;
      subevent_select <= hqvs_pkg::SUBSEL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hqvs_pkg::REG_HARMONIC: begin
          harmonic <= cfg_data[hqvs_pkg::HARM_W-1:0];
        end
        hqvs_pkg::REG_PARTICLE_TYPE: begin
          particle_type <= cfg_data[hqvs_pkg::PTYPE_W-1:0];
        end
        hqvs_pkg::REG_SUBEVENT_SELECT: begin
          subevent_select <= $signed(cfg_data[hqvs_pkg::SUBSEL_W-1:0]);
        end
        default: begin
        end
      endcase
    end
  end

  // phase, half-turn fold, weight product and particle selection
  always_comb begin
    harm_prod   = harmonic * phi_angle;
    phase       = hqvs_pkg::PHASE_W'(harm_prod[hqvs_pkg::ANGLE_BITS-1:0])
                  << (hqvs_pkg::PHASE_W - hqvs_pkg::ANGLE_BITS);
    neg         = phase[hqvs_pkg::PHASE_W-1] ^ phase[hqvs_pkg::PHASE_W-2];
    z_fold      = {phase[hqvs_pkg::PHASE_W-1] ^ neg, phase[hqvs_pkg::PHASE_W-2:0]};
    weight_prod = $signed(extra_weight) * $signed({1'b0, particle_weight});
    type_ok     = (32'(particle_type) < hqvs_pkg::TYPE_COUNT) && type_bits[particle_type];
    sub_ok      = subevent_select[hqvs_pkg::SUBSEL_W-1]
                  || ((32'(subevent_select[hqvs_pkg::SUBSEL_W-2:0]) < hqvs_pkg::SUBEVENT_COUNT)
                      && subevent_bits[subevent_select[hqvs_pkg::SUBSEL_W-2:0]]);
    ctrl_in.load     = !operation;
    ctrl_in.sel      = type_ok && sub_ok;
    ctrl_in.daughter = is_daughter;
    ctrl_in.neg      = neg;
  end

  // item register, held while the item is in flight
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_ctrl   <= ctrl_in;
      item_weight <= weight_prod;
      item_z      <= $signed({z_fold[hqvs_pkg::PHASE_W-1], z_fold});
      item_lx     <= load_x;
      item_ly     <= load_y;
    end
  end

  // occupancy and launch into the rotator row
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      start <= 1'b0;
    end else begin
      start <= in_xfer;
      if (in_xfer) begin
        busy <= 1'b1;
      end else if (done) begin
        busy <= 1'b0;
      end
    end
  end

  // start vector into the first cell
  assign chain[0] = '{valid: start, x: hqvs_pkg::CORDIC_X0, y: '0, z: item_z};

  // rotator row, one micro-rotation per cell
  for (genvar k = 0; k < hqvs_pkg::CORDIC_STEPS; k++) begin : g_cell
    hqvs_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .step (hqvs_pkg::STEP_W'(k)),
      .din  (chain[k]),
      .dout (chain[k+1])
    );
  end

  hqvs_update u_update (
    .clk                  (clk),
    .rst                  (rst),
    .fin                  (chain[hqvs_pkg::CORDIC_STEPS]),
    .ctrl                 (item_ctrl),
    .weight               (item_weight),
    .load_x               (item_lx),
    .load_y               (item_ly),
    .out_ready            (out_ready),
    .out_valid            (out_valid),
    .vector_x             (vector_x),
    .vector_y             (vector_y),
    .daughters_subtracted (daughters_subtracted),
    .was_selected         (was_selected),
    .done                 (done)
  );

endmodule

/* src/hqvs_checker.sv */
`timescale 1ns / 1ps

module hqvs_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [hqvs_pkg::IO_W-1:0]   vector_x,
  input logic signed [hqvs_pkg::IO_W-1:0]   vector_y,
  input logic [hqvs_pkg::COUNT_W-1:0]       daughters_subtracted,
  input logic                               was_selected
);

  // one item in flight: input closes after a transfer
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input still open after a transfer");

  // no result lands right after an input transfer
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared too early");

  // input reopens when a result lands
  a_reopen: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("input not reopened with new result");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(vector_x) && $stable(vector_y)
      && $stable(daughters_subtracted) && $stable(was_selected))
    else $error("stalled result changed");

endmodule

bind harmonic_q_vector_subtract hqvs_checker u_hqvs_checker (.*);

/* tb/q_vector_checker.sv */
`timescale 1ns / 1ps

module q_vector_checker
  import hqvs_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic                         operation,
  input  logic signed [IO_W-1:0]       load_x,
  input  logic signed [IO_W-1:0]       load_y,
  input  logic [ANGLE_BITS-1:0]        phi_angle,
  input  logic [WEIGHT_W-1:0]          particle_weight,
  input  logic signed [WEIGHT_W-1:0]   extra_weight,
  input  logic [MASK_W-1:0]            type_bits,
  input  logic [MASK_W-1:0]            subevent_bits,
  input  logic                         is_daughter,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic signed [IO_W-1:0]       vector_x,
  input  logic signed [IO_W-1:0]       vector_y,
  input  logic [COUNT_W-1:0]           daughters_subtracted,
  input  logic                         was_selected,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  output int                           mismatch_count,
  output int                           results_pending
);

  typedef struct {
    logic signed [IO_W-1:0] x;
    logic signed [IO_W-1:0] y;
    logic [COUNT_W-1:0]     daughters;
    logic                   selected;
  } q_result_t;

  // results predicted at input transfers, oldest first
  q_result_t expected_q[$];

  // shadow of the configuration and the vector state
  logic [HARM_W-1:0]          harmonic_reg;
  logic [PTYPE_W-1:0]         ptype_reg;
  logic signed [SUBSEL_W-1:0] subsel_reg;
  longint                     acc_x;
  longint                     acc_y;
  logic [COUNT_W-1:0]         daughter_cnt;
  int                         errors = 0;
  int                         result_idx = 0;

  initial begin
    mismatch_count  = 0;
    results_pending = 0;
  end

  // clamp to the signed accumulator range
  function automatic longint clamp_acc(input longint v);
    longint hi_lim;
    longint lo_lim;
    hi_lim = (longint'(1) <<< (ACC_BITS - 1)) - 1;
    lo_lim = -hi_lim - 1;
    if (v > hi_lim) return hi_lim;
    if (v < lo_lim) return lo_lim;
    return v;
  endfunction

  // cosine and sine of a 32-bit turn fraction, Q2.30, by shift-add rotation
  function automatic void rotate_turn(input logic [PHASE_W-1:0] phase,
                                      output longint cos_q, output longint sin_q);
    longint x;
    longint y;
    longint z;
    longint t;
    logic [PHASE_W-1:0] ph;
    logic flip;
    ph   = phase;
    flip = 1'b0;
    // left half plane: turn by half a turn and negate at the end
    if (ph >= 32'h4000_0000 && ph < 32'hC000_0000) begin
      ph   = ph - 32'h8000_0000;
      flip = 1'b1;
    end
    x = longint'(CORDIC_X0);
    y = 0;
    z = longint'($signed(ph));
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z = z - longint'(ATAN_TURN[i]);
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z = z + longint'(ATAN_TURN[i]);
      end
      x = t;
    end
    cos_q = flip ? -x : x;
    sin_q = flip ? -y : y;
  endfunction

  // apply the item on the input port to the shadow state, return its result
  function automatic q_result_t predict_q_vector();
    q_result_t r;
    logic ok;
    logic [31:0] turn_prod;
    logic [PHASE_W-1:0] phase;
    longint c;
    longint s;
    longint p;
    longint half;
    half = longint'(1) <<< (ROUND_SHIFT - 1);
    r.selected = 1'b0;
    if (operation == 1'b0) begin
      acc_x = clamp_acc(longint'(load_x));
      acc_y = clamp_acc(longint'(load_y));
    end else begin
      ok = (ptype_reg < TYPE_COUNT) && type_bits[ptype_reg];
      if (subsel_reg >= 0) begin
        if (subsel_reg >= SUBEVENT_COUNT || !subevent_bits[subsel_reg[SUBSEL_W-2:0]]) begin
          ok = 1'b0;
        end
      end
      // a parent restarts the daughter count, selected or not
      if (!is_daughter) daughter_cnt = '0;
      if (ok) begin
        turn_prod = 32'(harmonic_reg) * 32'(phi_angle);
        phase = {turn_prod[ANGLE_BITS-1:0], {(PHASE_W-ANGLE_BITS){1'b0}}};
        rotate_turn(phase, c, s);
        p = longint'(extra_weight) * longint'(particle_weight);
        acc_x = clamp_acc(acc_x - ((p * c + half) >>> ROUND_SHIFT));
        acc_y = clamp_acc(acc_y - ((p * s + half) >>> ROUND_SHIFT));
        r.selected = 1'b1;
        if (is_daughter && daughter_cnt != '1) daughter_cnt = daughter_cnt + 1'b1;
      end
    end
    r.x         = acc_x[IO_W-1:0];
    r.y         = acc_y[IO_W-1:0];
    r.daughters = daughter_cnt;
    return r;
  endfunction

  // watch all three channels
  always @(posedge clk) begin
    q_result_t got;
    q_result_t want;
    if (rst) begin
      harmonic_reg = HARMONIC_RST;
      ptype_reg    = PTYPE_RST;
      subsel_reg   = SUBSEL_RST;
      acc_x        = 0;
      acc_y        = 0;
      daughter_cnt = '0;
      expected_q.delete();
    end else begin
      // result transfer against the oldest prediction
      if (out_valid && out_ready) begin
        got.x         = vector_x;
        got.y         = vector_y;
        got.daughters = daughters_subtracted;
        got.selected  = was_selected;
        if (expected_q.size() == 0) begin
          if (errors < 10) begin
            $display("result %0d arrived with nothing pending: x %0d y %0d daughters %0d sel %0b",
                     result_idx, got.x, got.y, got.daughters, got.selected);
          end
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.daughters !== want.daughters ||
              got.selected !== want.selected) begin
            if (errors < 10) begin
              $display("result %0d wrong (expected/actual): x %0d/%0d y %0d/%0d", result_idx,
                       want.x, got.x, want.y, got.y);
              $display("  daughters %0d/%0d selected %0b/%0b", want.daughters, got.daughters,
                       want.selected, got.selected);
            end
            errors++;
          end
        end
        result_idx++;
      end
      // item transfer
      if (in_valid && in_ready) begin
        expected_q.push_back(predict_q_vector());
      end
      // register write
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_HARMONIC:        harmonic_reg = cfg_data[HARM_W-1:0];
          REG_PARTICLE_TYPE:   ptype_reg    = cfg_data[PTYPE_W-1:0];
          REG_SUBEVENT_SELECT: subsel_reg   = cfg_data[SUBSEL_W-1:0];
          default: ;
        endcase
      end
    end
    mismatch_count  <= errors;
    results_pending <= expected_q.size();
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import hqvs_pkg::*;

  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int DRAIN_CYCLES     = 60;
  localparam int N_CONFIGS        = 8;
  localparam int ITEMS_PER_CONFIG = 165;
  localparam int LONG_CHAIN       = 270;

  // register settings walked through by the random part
  localparam int CFG_HARMONIC [N_CONFIGS] = '{1, 15, 0, 2, 7, 3, 15, 1};
  localparam int CFG_PTYPE    [N_CONFIGS] = '{0, 7, 3, 5, 1, 6, 0, 7};
  localparam int CFG_SUBSEL   [N_CONFIGS] = '{-1, 7, 0, -8, 3, -1, 5, -1};

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic                        operation = 1'b0;
  logic signed [IO_W-1:0]      load_x = '0;
  logic signed [IO_W-1:0]      load_y = '0;
  logic [ANGLE_BITS-1:0]       phi_angle = '0;
  logic [WEIGHT_W-1:0]         particle_weight = '0;
  logic signed [WEIGHT_W-1:0]  extra_weight = '0;
  logic [MASK_W-1:0]           type_bits = '0;
  logic [MASK_W-1:0]           subevent_bits = '0;
  logic                        is_daughter = 1'b0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic signed [IO_W-1:0]      vector_x;
  logic signed [IO_W-1:0]      vector_y;
  logic [COUNT_W-1:0]          daughters_subtracted;
  logic                        was_selected;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [CFG_DATA_W-1:0]       cfg_data = '0;

  int mismatch_count;
  int results_pending;
  int send_idle_pct = 34;
  int recv_idle_pct = 52;
  int stall_cycles = 0;

  logic [PTYPE_W-1:0]          cur_ptype = PTYPE_RST;
  logic signed [SUBSEL_W-1:0]  cur_subsel = SUBSEL_RST;

  harmonic_q_vector_subtract dut (.*);

  q_vector_checker checker_i (.*);

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // end the run when no transfer happens for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("harmonic_q_vector_subtract: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // offer one item, with random idle cycles ahead of it, until its transfer
  task automatic present_item(input logic op, input logic [IO_W-1:0] lx,
                              input logic [IO_W-1:0] ly, input logic [ANGLE_BITS-1:0] phi,
                              input logic [WEIGHT_W-1:0] w, input logic [WEIGHT_W-1:0] ew,
                              input logic [MASK_W-1:0] tb, input logic [MASK_W-1:0] sb,
                              input logic dau);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    operation       <= op;
    load_x          <= lx;
    load_y          <= ly;
    phi_angle       <= phi;
    particle_weight <= w;
    extra_weight    <= ew;
    type_bits       <= tb;
    subevent_bits   <= sb;
    is_daughter     <= dau;
    in_valid        <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // hold off input until every predicted result has come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
  endtask

  task automatic write_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // load with values often close to the saturation limits
  task automatic send_load();
    logic [IO_W-1:0] lx;
    logic [IO_W-1:0] ly;
    lx = $urandom;
    ly = $urandom;
    if ($urandom_range(0, 99) < 30) lx = 32'h7FFF_FFFF - $urandom_range(0, 1 << 22);
    else if ($urandom_range(0, 99) < 30) lx = 32'h8000_0000 + $urandom_range(0, 1 << 22);
    if ($urandom_range(0, 99) < 30) ly = 32'h7FFF_FFFF - $urandom_range(0, 1 << 22);
    else if ($urandom_range(0, 99) < 30) ly = 32'h8000_0000 + $urandom_range(0, 1 << 22);
    present_item(1'b0, lx, ly, ANGLE_BITS'($urandom), WEIGHT_W'($urandom),
                 WEIGHT_W'($urandom), MASK_W'($urandom), MASK_W'($urandom),
                 1'($urandom_range(0, 1)));
  endtask

  // particle; a well-formed one mostly passes the current type and subevent cut
  task automatic send_particle(input logic dau, input bit well_formed);
    logic [MASK_W-1:0] tb;
    logic [MASK_W-1:0] sb;
    logic [WEIGHT_W-1:0] w;
    logic [WEIGHT_W-1:0] ew;
    tb = MASK_W'($urandom);
    sb = MASK_W'($urandom);
    if (well_formed) begin
      tb[cur_ptype] = ($urandom_range(0, 99) < 75);
      if (cur_subsel >= 0) sb[cur_subsel[SUBSEL_W-2:0]] = ($urandom_range(0, 99) < 80);
    end
    case ($urandom_range(0, 9))
      0:       w = '0;
      1:       w = '1;
      default: w = WEIGHT_W'($urandom);
    endcase
    case ($urandom_range(0, 9))
      0:       ew = 16'h8000;
      1:       ew = 16'h7FFF;
      2:       ew = '0;
      default: ew = WEIGHT_W'($urandom);
    endcase
    present_item(1'b1, $urandom, $urandom, ANGLE_BITS'($urandom), w, ew, tb, sb, dau);
  endtask

  initial begin
    int sent;
    int roll;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // directed part at reset settings: harmonic 2, type 0, no subevent cut
    // saturate X high, then Y low at a quarter turn
    present_item(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0, '0, '0, '0, '0, 1'b0);
    present_item(1'b1, '0, '0, 16'h0000, 16'hFFFF, 16'h8000, 8'h01, 8'h00, 1'b0);
    present_item(1'b0, 32'h8000_0000, 32'h8000_0000, '0, '0, '0, '0, '0, 1'b0);
    present_item(1'b1, '0, '0, 16'h2000, 16'hFFFF, 16'h7FFF, 8'hFF, 8'hFF, 1'b0);
    // load ignores particle fields
    present_item(1'b0, '0, '0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 1'b1);
    // quadrant boundaries of the phase
    present_item(1'b1, '0, '0, 16'hFFFF, 16'h1000, 16'h1000, 8'h01, 8'h00, 1'b0);
    present_item(1'b1, '0, '0, 16'h4000, 16'h1000, 16'h1000, 8'h01, 8'h00, 1'b1);
    present_item(1'b1, '0, '0, 16'h8000, 16'h1000, 16'h1000, 8'h01, 8'h00, 1'b1);
    present_item(1'b1, '0, '0, 16'hC000, 16'h1000, 16'h1000, 8'h01, 8'h00, 1'b1);
    present_item(1'b1, '0, '0, 16'h3FFF, 16'h1000, 16'h1000, 8'h01, 8'h00, 1'b1);
    present_item(1'b1, '0, '0, 16'h6000, 16'hFFFF, 16'h8000, 8'h01, 8'h00, 1'b1);
    // daughter without the type bit leaves the count alone
    present_item(1'b1, '0, '0, 16'h1234, 16'h1000, 16'h1000, 8'hFE, 8'hFF, 1'b1);
    // zero weights
    present_item(1'b1, '0, '0, 16'h1234, 16'h0000, 16'h7FFF, 8'h01, 8'h00, 1'b1);
    present_item(1'b1, '0, '0, 16'h1234, 16'hFFFF, 16'h0000, 8'h01, 8'h00, 1'b1);
    // load keeps the daughter count, next daughter continues it
    present_item(1'b0, 32'h1234_5678, 32'hEDCB_A987, '0, '0, '0, '0, '0, 1'b0);
    present_item(1'b1, '0, '0, 16'h0800, 16'h2000, 16'hF000, 8'h01, 8'h00, 1'b1);
    // unselected parent still restarts the count
    present_item(1'b1, '0, '0, 16'h0800, 16'h2000, 16'hF000, 8'h00, 8'hFF, 1'b0);
    present_item(1'b1, '0, '0, 16'hA5A5, 16'h5A5A, 16'h5A5A, 8'h01, 8'h00, 1'b1);
    present_item(1'b1, '0, '0, 16'h1000, 16'h8000, 16'hFFFF, 8'h55, 8'hAA, 1'b0);
    present_item(1'b1, '0, '0, 16'h7FFF, 16'hFFFF, 16'h8000, 8'h01, 8'h00, 1'b1);

    // random part, one register setting at a time
    for (int cfg_i = 0; cfg_i < N_CONFIGS; cfg_i++) begin
      wait_drained();
      cur_ptype  = PTYPE_W'(CFG_PTYPE[cfg_i]);
      cur_subsel = SUBSEL_W'(CFG_SUBSEL[cfg_i]);
      write_register(REG_HARMONIC, CFG_DATA_W'(CFG_HARMONIC[cfg_i]));
      write_register(REG_PARTICLE_TYPE, CFG_DATA_W'(cur_ptype));
      write_register(REG_SUBEVENT_SELECT, CFG_DATA_W'(cur_subsel));
      if (cfg_i < 3) begin
        send_idle_pct = 34;
        recv_idle_pct = 52;
      end else if (cfg_i < 6) begin
        send_idle_pct = 52;
        recv_idle_pct = 34;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      // one long family to drive the daughter count into saturation
      if (cfg_i == 2) begin
        present_item(1'b1, '0, '0, ANGLE_BITS'($urandom), WEIGHT_W'($urandom),
                     WEIGHT_W'($urandom), 8'hFF, 8'hFF, 1'b0);
        repeat (LONG_CHAIN) begin
          present_item(1'b1, '0, '0, ANGLE_BITS'($urandom), WEIGHT_W'($urandom),
                       WEIGHT_W'($urandom), 8'hFF, 8'hFF, 1'b1);
        end
      end

      sent = 0;
      while (sent < ITEMS_PER_CONFIG) begin
        roll = $urandom_range(0, 99);
        if (roll == 0) wait_drained();
        if (roll < 8) begin
          send_load();
          sent++;
        end else if (roll < 14) begin
          // noise: any fields, any parentage
          send_particle(1'($urandom_range(0, 1)), 1'b0);
          sent++;
        end else begin
          // parent followed by its daughters
          send_particle(1'b0, 1'b1);
          sent++;
          repeat ($urandom_range(0, 10)) begin
            send_particle(1'b1, 1'b1);
            sent++;
          end
        end
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("harmonic_q_vector_subtract: match");
    end else begin
      $display("harmonic_q_vector_subtract: mismatch");
    end
    $finish;
  end

endmodule
